// File: design/fum_pkg.sv
// Shared types and constants for the frame utilization meter.
`default_nettype none

package fum_pkg;

	localparam int FUM_HISTORY_DEPTH = 64;

	localparam int FUM_AMOUNT_W = 64;
	localparam int FUM_CYCLE_W  = 32;
	localparam int FUM_PCT_W    = 8;
	localparam int FUM_SLOT_W   = 6;

	// a * 100 fits in 64 + 7 bits
	localparam int FUM_NUM_W  = FUM_AMOUNT_W + 7;
	localparam int FUM_STEP_W = $clog2(FUM_NUM_W);

	// cycles * 2 before the divide by 333
	localparam int FUM_CO_NUM_W  = FUM_CYCLE_W + 1;
	localparam int FUM_CO_STEP_W = $clog2(FUM_CO_NUM_W);
	localparam int FUM_CO_REM_W  = 9;
	localparam logic [FUM_CO_REM_W:0] FUM_CO_DIVISOR = (FUM_CO_REM_W + 1)'(333);

	localparam logic [FUM_PCT_W:0] FUM_PCT_MAX = (FUM_PCT_W + 1)'(200);

	localparam logic FUM_KIND_FRAME = 1'b0;
	localparam logic FUM_KIND_READ  = 1'b1;

	typedef enum logic [1:0] {
		MODE_ADD_WAIT   = 2'd0,
		MODE_ADD_COPROC = 2'd1,
		MODE_END_FRAME  = 2'd2,
		MODE_READ       = 2'd3
	} fum_mode_t;

	typedef struct packed {
		fum_mode_t                 mode;
		logic [FUM_AMOUNT_W-1:0]   amount;
		logic [FUM_SLOT_W-1:0]     slot;
	} fum_item_t;

	typedef struct packed {
		logic                    kind;
		logic [FUM_PCT_W-1:0]    main_percent;
		logic [FUM_PCT_W-1:0]    coproc_percent;
		logic [FUM_SLOT_W-1:0]   head_slot;
	} fum_result_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SLOT,
		ST_READ,
		ST_BUSY,
		ST_CODIV,
		ST_START,
		ST_DIVWAIT,
		ST_STORE
	} fum_state_t;

	typedef enum logic [1:0] {
		DV_IDLE,
		DV_MUL,
		DV_RUN,
		DV_DONE
	} fum_div_state_t;

endpackage

`default_nettype wire

// File: design/fum_ratio_div.sv
// Bit-serial divider: floor(numer * 100 / denom), clamped to 200.
`default_nettype none

module fum_ratio_div (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	input  logic [fum_pkg::FUM_AMOUNT_W-1:0]     numer,
	input  logic [fum_pkg::FUM_AMOUNT_W-1:0]     denom,
	output logic                                 done,
	output logic [fum_pkg::FUM_PCT_W-1:0]        ratio
);
	import fum_pkg::*;

	// numer must hold from start through the DV_MUL cycle
	localparam logic [FUM_STEP_W-1:0] STEP_LAST = FUM_STEP_W'(FUM_NUM_W - 1);

	fum_div_state_t              state_q, state_nx;
	logic [FUM_NUM_W-1:0]        num_q;
	logic [FUM_AMOUNT_W-1:0]     den_q;
	logic [FUM_AMOUNT_W-1:0]     rem_q;
	logic [FUM_STEP_W-1:0]       step_q;
	logic [FUM_PCT_W-1:0]        quo_q;
	logic                        sat_q;

	logic [FUM_AMOUNT_W:0]       rem_sh;
	logic [FUM_AMOUNT_W+1:0]     rem_diff;
	logic                        q_bit;
	logic [FUM_AMOUNT_W-1:0]     rem_nx;
	logic [FUM_PCT_W:0]          quo_t;
	logic                        over;

	// restoring step: shift in the next numerator bit, try the subtract
	assign rem_sh   = {rem_q, num_q[FUM_NUM_W-1]};
	assign rem_diff = {1'b0, rem_sh} - {2'b00, den_q};
	assign q_bit    = !rem_diff[FUM_AMOUNT_W+1];
	assign rem_nx   = q_bit ? rem_diff[FUM_AMOUNT_W-1:0] : rem_sh[FUM_AMOUNT_W-1:0];

	// only the clamped quotient is kept
	assign quo_t = {quo_q, q_bit};
	assign over  = sat_q || (quo_t > FUM_PCT_MAX);

	assign done  = (state_q == DV_DONE);
	assign ratio = sat_q ? FUM_PCT_MAX[FUM_PCT_W-1:0] : quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= DV_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		case (state_q)
			DV_IDLE: begin
				if (start) state_nx = DV_MUL;
			end
			DV_MUL: begin
				state_nx = DV_RUN;
			end
			DV_RUN: begin
				if (step_q == STEP_LAST) state_nx = DV_DONE;
			end
			DV_DONE: begin
				state_nx = DV_IDLE;
			end
			default: begin
				state_nx = DV_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		case (state_q)
			DV_IDLE: begin
				if (start) begin
					// x100 = x64 + x32 + x4, last term added next cycle
					num_q  <= FUM_NUM_W'({numer, 6'b0}) + FUM_NUM_W'({numer, 5'b0});
					den_q  <= denom;
					rem_q  <= '0;
					quo_q  <= '0;
					sat_q  <= 1'b0;
					step_q <= '0;
				end
			end
			DV_MUL: begin
				num_q <= num_q + FUM_NUM_W'({numer, 2'b0});
			end
			DV_RUN: begin
				num_q  <= {num_q[FUM_NUM_W-2:0], 1'b0};
				rem_q  <= rem_nx;
				sat_q  <= over;
				if (!over) quo_q <= quo_t[FUM_PCT_W-1:0];
				step_q <= step_q + 1'b1;
			end
			default: begin
			end
		endcase
	end

endmodule

`default_nettype wire

// File: design/frame_utilization_meter_unit.sv
// Frame utilization meter: per-frame busy percentages and a history ring.
// Add events are taken one per cycle while idle; a history read passes ST_SLOT
//   (slot wrap, only for depths under 64) and ST_READ; a measured frame end
//   runs the 33-step /333 loop, then the 71-step bit-serial percent dividers.
//   No new item is taken until a read or frame end has finished.
// Reset: sums, timestamp and head clear at once; the history memory is then
//   zeroed entry by entry, during which no transaction is taken.
`default_nettype none

module frame_utilization_meter_unit #(
	parameter int HISTORY_DEPTH = fum_pkg::FUM_HISTORY_DEPTH
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  item_valid,
	output logic                  item_ready,
	input  fum_pkg::fum_item_t    item,
	output logic                  result_valid,
	input  logic                  result_ready,
	output fum_pkg::fum_result_t  result
);
	import fum_pkg::*;

	// index width of the history ring; slot and head_slot are 6 bits wide
	localparam int HW    = $clog2(HISTORY_DEPTH);
	localparam int EXT_W = (HW > FUM_SLOT_W) ? HW : FUM_SLOT_W;
	localparam int MEM_W = 2 * FUM_PCT_W;

	localparam logic [HW-1:0]      DEPTH_LAST = HW'(HISTORY_DEPTH - 1);
	localparam logic [EXT_W:0]     DEPTH_CMP  = (EXT_W + 1)'(HISTORY_DEPTH);
	localparam logic [EXT_W-1:0]   DEPTH_SUB  = EXT_W'(HISTORY_DEPTH);
	localparam logic [FUM_CO_STEP_W-1:0] CO_LAST = FUM_CO_STEP_W'(FUM_CO_NUM_W - 1);

	// ---------------------------------------------------------------------
	// State
	// ---------------------------------------------------------------------
	fum_state_t                    state_q, state_nx;

	logic [FUM_AMOUNT_W-1:0]       wait_sum_q;
	logic [FUM_CYCLE_W-1:0]        co_sum_q;
	logic [FUM_AMOUNT_W-1:0]       last_q;
	logic [HW-1:0]                 head_q;
	logic [HW-1:0]                 clr_q;

	logic [FUM_AMOUNT_W-1:0]       period_q;
	logic                          meas_q;
	logic [FUM_AMOUNT_W-1:0]       busy_q;
	logic [FUM_CO_NUM_W-1:0]       co_num_q;
	logic [FUM_CO_REM_W-1:0]       co_rem_q;
	logic [FUM_CO_STEP_W-1:0]      co_step_q;
	logic [EXT_W-1:0]              slot_q;
	logic [FUM_PCT_W-1:0]          mp_q, cp_q;

	logic                          out_valid_q;
	fum_result_t                   out_q;

	// history: main percent in the upper byte, coprocessor in the lower
	logic [MEM_W-1:0]              mem [HISTORY_DEPTH];
	logic [MEM_W-1:0]              rd_q;

	// ---------------------------------------------------------------------
	// Combinational helpers
	// ---------------------------------------------------------------------
	logic                          accept;
	logic                          out_free;
	logic                          out_load;
	logic                          mem_we;
	logic [HW-1:0]                 mem_wa;
	logic [MEM_W-1:0]              mem_wd;
	logic [HW-1:0]                 mem_ra;
	logic                          div_start;
	logic                          main_done, co_done;
	logic [FUM_PCT_W-1:0]          main_ratio, co_ratio;
	logic [HW-1:0]                 head_nx;
	logic [HW-1:0]                 head_sel;
	logic [EXT_W-1:0]              head_ext;
	logic                          slot_big;
	logic [FUM_AMOUNT_W:0]         period_c;
	logic [FUM_AMOUNT_W:0]         busy_c;
	logic [FUM_CO_REM_W:0]         co_rem_t;
	logic                          co_ge;
	logic [FUM_CO_REM_W:0]         co_rem_sub;
	fum_result_t                   out_nx;

	assign accept   = item_valid && item_ready;
	assign out_free = !out_valid_q || result_ready;

	// period and the "new stamp is later" test share one subtract:
	// no borrow and a nonzero difference means amount > last
	assign period_c = {1'b0, item.amount} - {1'b0, last_q};

	// busy time, floored at zero when wait exceeds the period
	assign busy_c = {1'b0, period_q} - {1'b0, wait_sum_q};

	// one restoring step of cycles*2 / 333, MSB first
	assign co_rem_t   = {co_rem_q, co_num_q[FUM_CO_NUM_W-1]};
	assign co_ge      = (co_rem_t >= FUM_CO_DIVISOR);
	assign co_rem_sub = co_rem_t - FUM_CO_DIVISOR;

	// slot wrap: subtract the depth one step a cycle (only for depths under 64)
	assign slot_big = ({1'b0, slot_q} >= DEPTH_CMP);
	assign mem_ra   = slot_q[HW-1:0];

	assign head_nx  = (head_q == DEPTH_LAST) ? '0 : head_q + 1'b1;
	assign head_sel = (state_q == ST_STORE) ? head_nx : head_q;
	assign head_ext = EXT_W'(head_sel);

	always_comb begin
		out_nx.head_slot = head_ext[FUM_SLOT_W-1:0];
		if (state_q == ST_READ) begin
			out_nx.kind           = FUM_KIND_READ;
			out_nx.main_percent   = rd_q[MEM_W-1:FUM_PCT_W];
			out_nx.coproc_percent = rd_q[FUM_PCT_W-1:0];
		end else begin
			out_nx.kind           = FUM_KIND_FRAME;
			out_nx.main_percent   = mp_q;
			out_nx.coproc_percent = cp_q;
		end
	end

	// ---------------------------------------------------------------------
	// Percent dividers, run side by side on the same period
	// ---------------------------------------------------------------------
	fum_ratio_div u_main_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.numer  (busy_q),
		.denom  (period_q),
		.done   (main_done),
		.ratio  (main_ratio)
	);

	fum_ratio_div u_co_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.numer  (FUM_AMOUNT_W'(co_num_q)),
		.denom  (period_q),
		.done   (co_done),
		.ratio  (co_ratio)
	);

	// ---------------------------------------------------------------------
	// Sequencer
	// ---------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx   = state_q;
		item_ready = 1'b0;
		mem_we     = 1'b0;
		mem_wa     = clr_q;
		mem_wd     = '0;
		div_start  = 1'b0;
		out_load   = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				// zero one history entry per cycle after reset
				mem_we = 1'b1;
				if (clr_q == DEPTH_LAST) state_nx = ST_IDLE;
			end
			ST_IDLE: begin
				item_ready = 1'b1;
				if (item_valid) begin
					case (item.mode)
						MODE_END_FRAME: state_nx = ST_BUSY;
						MODE_READ:      state_nx = ST_SLOT;
						default:        state_nx = ST_IDLE;
					endcase
				end
			end
			ST_SLOT: begin
				// rd_q picks up the entry on the edge that leaves this state
				if (!slot_big) state_nx = ST_READ;
			end
			ST_READ: begin
				if (out_free) begin
					out_load = 1'b1;
					state_nx = ST_IDLE;
				end
			end
			ST_BUSY: begin
				state_nx = meas_q ? ST_CODIV : ST_IDLE;
			end
			ST_CODIV: begin
				if (co_step_q == CO_LAST) state_nx = ST_START;
			end
			ST_START: begin
				div_start = 1'b1;
				state_nx  = ST_DIVWAIT;
			end
			ST_DIVWAIT: begin
				if (main_done) state_nx = ST_STORE;
			end
			ST_STORE: begin
				// head advances, entry written and result loaded together
				if (out_free) begin
					mem_we   = 1'b1;
					mem_wa   = head_nx;
					mem_wd   = {mp_q, cp_q};
					out_load = 1'b1;
					state_nx = ST_IDLE;
				end
			end
			default: begin
				state_nx = ST_IDLE;
			end
		endcase
	end

	// ---------------------------------------------------------------------
	// Architectural state: sums, timestamp, head, clear counter, output flag
	// ---------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wait_sum_q  <= '0;
			co_sum_q    <= '0;
			last_q      <= '0;
			head_q      <= '0;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				case (item.mode)
					MODE_ADD_WAIT:   wait_sum_q <= wait_sum_q + item.amount;
					MODE_ADD_COPROC: co_sum_q   <= co_sum_q + item.amount[FUM_CYCLE_W-1:0];
					MODE_END_FRAME:  last_q     <= item.amount;
					default: begin
					end
				endcase
			end
			// every frame end clears both sums, measured or not
			if (state_q == ST_BUSY) begin
				wait_sum_q <= '0;
				co_sum_q   <= '0;
			end
			if (state_q == ST_CLEAR) clr_q <= clr_q + 1'b1;
			if (state_q == ST_STORE && out_free) head_q <= head_nx;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// ---------------------------------------------------------------------
	// Datapath registers
	// ---------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (accept) begin
			period_q <= period_c[FUM_AMOUNT_W-1:0];
			meas_q   <= (last_q != '0) && !period_c[FUM_AMOUNT_W] &&
			            (period_c[FUM_AMOUNT_W-1:0] != '0);
			slot_q   <= EXT_W'(item.slot);
		end
		case (state_q)
			ST_SLOT: begin
				if (slot_big) slot_q <= slot_q - DEPTH_SUB;
			end
			ST_BUSY: begin
				busy_q    <= busy_c[FUM_AMOUNT_W] ? '0 : busy_c[FUM_AMOUNT_W-1:0];
				co_num_q  <= {co_sum_q, 1'b0};
				co_rem_q  <= '0;
				co_step_q <= '0;
			end
			ST_CODIV: begin
				// quotient bits shift in behind the dividend
				co_num_q  <= {co_num_q[FUM_CO_NUM_W-2:0], co_ge};
				co_rem_q  <= co_ge ? co_rem_sub[FUM_CO_REM_W-1:0]
				                   : co_rem_t[FUM_CO_REM_W-1:0];
				co_step_q <= co_step_q + 1'b1;
			end
			ST_DIVWAIT: begin
				if (main_done) begin
					mp_q <= main_ratio;
					cp_q <= co_ratio;
				end
			end
			default: begin
			end
		endcase
		if (out_load) out_q <= out_nx;
	end

	// ---------------------------------------------------------------------
	// History memory: one write port, one registered read port
	// ---------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_wa] <= mem_wd;
		rd_q <= mem[mem_ra];
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

	// ---------------------------------------------------------------------
	// Assertions
	// ---------------------------------------------------------------------
	a_div_lockstep: assert property (@(posedge clk) disable iff (!arst_n)
		main_done |-> co_done)
		else $error("percent dividers out of step");

	a_pct_clamp: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> ({1'b0, result.main_percent} <= FUM_PCT_MAX) &&
		                 ({1'b0, result.coproc_percent} <= FUM_PCT_MAX))
		else $error("percent above clamp");

	a_mem_write_src: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (state_q == ST_CLEAR || state_q == ST_STORE))
		else $error("history write outside clear or store");

	a_head_moves: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) && out_q.kind == FUM_KIND_FRAME |-> head_q != $past(head_q))
		else $error("frame result without head advance");

endmodule

`default_nettype wire
